@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each macro samples on clk_i and is disabled while
// rst_ni is low, so the including scope must have both signals.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TDR_ASSERT_NEVER(lbl, prop, msg) \
  `TDR_ASSERT(lbl, !(prop), msg)

`endif

@@ src/tdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// Types, opcodes and time constants shared by the time-of-day register.
// ----------------------------------------------------------------------------
package tdr_pkg;

  // Time constants.
  localparam int MINUTE_SECONDS = 60;
  localparam int HOUR_SECONDS   = 3600;
  localparam int HOURS_PER_DAY  = 24;
  localparam int DAY_SECONDS    = HOURS_PER_DAY * HOUR_SECONDS;
  localparam int MAX_HOURS      = 23;
  localparam int MAX_MINUTES    = 59;
  localparam int MAX_SECONDS    = 59;

  // Widths of a time of day in seconds and of a signed difference.
  localparam int TOD_W  = 17;
  localparam int DIFF_W = 18;

  // Day folding: a multiple of a day that lifts every signed operand above zero,
  // and a reciprocal of the odd part of the day length.
  localparam longint FOLD_OFFSET =
      ((longint'(1) << 31) / DAY_SECONDS + 1) * DAY_SECONDS;
  localparam int     DAY_LOW_BITS    = 7;
  localparam int     DAY_ODD         = DAY_SECONDS >> DAY_LOW_BITS;
  localparam int     DAY_RECIP_SHIFT = 35;
  localparam longint DAY_RECIP       = (longint'(1) << DAY_RECIP_SHIFT) / DAY_ODD;

  // Reciprocals for splitting seconds into hours and minutes (rounded up).
  localparam int HOUR_LOW_BITS    = 4;
  localparam int HOUR_RECIP_SHIFT = 20;
  localparam int HOUR_RECIP =
      (1 << HOUR_RECIP_SHIFT) / (HOUR_SECONDS >> HOUR_LOW_BITS) + 1;
  localparam int MIN_RECIP_SHIFT  = 20;
  localparam int MIN_RECIP        = (1 << MIN_RECIP_SHIFT) / MINUTE_SECONDS + 1;

  // Opcodes. Codes six and seven are no-ops.
  typedef enum logic [2:0] {
    OP_SET_CHECKED = 3'd0,
    OP_SET_NORM    = 3'd1,
    OP_NEXT        = 3'd2,
    OP_PREV        = 3'd3,
    OP_SHIFT       = 3'd4,
    OP_DIFF        = 3'd5
  } op_e;

  typedef logic [TOD_W-1:0] tod_t;

  // Folded operand handed from the front end to the time register.
  typedef struct packed {
    logic [2:0] op;
    logic       fields_ok;
    tod_t       operand;
  } fold_t;

  // Time and side results handed from the time register to the splitter.
  typedef struct packed {
    tod_t                     total;
    logic signed [DIFF_W-1:0] diff;
    logic                     bad;
  } core_t;

endpackage

@@ src/tdr_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_fold
// Input register and front end: combines the fields into seconds, picks the
// shift offset where needed and folds the value into one day in three stages.
// ----------------------------------------------------------------------------
module tdr_fold (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic signed [15:0]  hours_in_i,
  input  logic signed [15:0]  minutes_in_i,
  input  logic signed [15:0]  seconds_in_i,
  input  logic signed [31:0]  shift_seconds_i,
  output logic                fold_valid_o,
  output tdr_pkg::fold_t      fold_o,
  input  logic                fold_rdy_i
);
  import tdr_pkg::*;

  logic                s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic                adv0, adv1, adv2, adv3;
  logic [2:0]          s0_op_q, s1_op_q, s2_op_q;
  logic signed [15:0]  s0_hrs_q, s0_min_q, s0_sec_q;
  logic signed [31:0]  s0_shift_q;
  logic                s1_ok_q, s2_ok_q;
  logic [32:0]         s1_u_q, s2_u_q;
  logic [TOD_W-1:0]    s2_q_q;
  logic signed [27:0]  given;
  logic signed [32:0]  fold_src;
  logic                fields_ok;
  logic [32:0]         s1_u_d;
  logic [51:0]         day_prod;
  logic [TOD_W-1:0]    s2_q_d;
  logic [32:0]         q_day;
  logic [32:0]         rem;
  fold_t               s3_d, s3_q;

  // Each stage moves when it is empty or its successor moves.
  assign adv3       = !s3_v_q || fold_rdy_i;
  assign adv2       = !s2_v_q || adv3;
  assign adv1       = !s1_v_q || adv2;
  assign adv0       = !s0_v_q || adv1;
  assign in_stall_o = !adv0;

  // Stage 1: fields to seconds, range check and offset into positive range.
  assign given = 28'(s0_hrs_q) * 28'(HOUR_SECONDS)
               + 28'(s0_min_q) * 28'(MINUTE_SECONDS)
               + 28'(s0_sec_q);
  assign fold_src  = (s0_op_q == OP_SHIFT) ? 33'(s0_shift_q) : 33'(given);
  assign s1_u_d    = 33'(fold_src + 33'(FOLD_OFFSET));
  assign fields_ok = !s0_hrs_q[15] && (s0_hrs_q <= 16'(MAX_HOURS))
                  && !s0_min_q[15] && (s0_min_q <= 16'(MAX_MINUTES))
                  && !s0_sec_q[15] && (s0_sec_q <= 16'(MAX_SECONDS));

  // Stage 2: day count estimate by reciprocal, low or exact by one.
  assign day_prod = 52'(s1_u_q[32:DAY_LOW_BITS]) * 52'(DAY_RECIP);
  assign s2_q_d   = TOD_W'(day_prod >> DAY_RECIP_SHIFT);

  // Stage 3: remainder with a single correcting subtract.
  assign q_day = 33'(34'(s2_q_q) * 34'(DAY_SECONDS));
  assign rem   = s2_u_q - q_day;

  always_comb begin
    s3_d.op        = s2_op_q;
    s3_d.fields_ok = s2_ok_q;
    if (rem >= 33'(DAY_SECONDS)) begin
      s3_d.operand = TOD_W'(rem - 33'(DAY_SECONDS));
    end else begin
      s3_d.operand = TOD_W'(rem);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (adv0) s0_v_q <= in_valid_i;
      if (adv1) s1_v_q <= s0_v_q;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv0 && in_valid_i) begin
      s0_op_q    <= opcode_i;
      s0_hrs_q   <= hours_in_i;
      s0_min_q   <= minutes_in_i;
      s0_sec_q   <= seconds_in_i;
      s0_shift_q <= shift_seconds_i;
    end
    if (adv1 && s0_v_q) begin
      s1_op_q <= s0_op_q;
      s1_ok_q <= fields_ok;
      s1_u_q  <= s1_u_d;
    end
    if (adv2 && s1_v_q) begin
      s2_op_q <= s1_op_q;
      s2_ok_q <= s1_ok_q;
      s2_u_q  <= s1_u_q;
      s2_q_q  <= s2_q_d;
    end
    if (adv3 && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  assign fold_valid_o = s3_v_q;
  assign fold_o       = s3_q;

endmodule

@@ src/tdr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_core
// Time register in seconds of the day. Loads set values, applies steps and
// shifts to the stored time by one add and a wrap; also forms differences.
// ----------------------------------------------------------------------------
module tdr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fold_valid_i,
  input  tdr_pkg::fold_t  fold_i,
  output logic            fold_rdy_o,
  output logic            core_valid_o,
  output tdr_pkg::core_t  core_o,
  input  logic            core_rdy_i
);
  import tdr_pkg::*;

  tod_t         total_q, total_d;
  tod_t         addend;
  tod_t         wrapped;
  logic [TOD_W:0] sum;
  logic         v_q;
  logic         adv, take;
  core_t        res_d, res_q;

  assign adv        = !v_q || core_rdy_i;
  assign take       = adv && fold_valid_i;
  assign fold_rdy_o = adv;

  // Step and shift share one modular adder.
  always_comb begin
    unique case (fold_i.op)
      OP_NEXT: addend = TOD_W'(1);
      OP_PREV: addend = TOD_W'(DAY_SECONDS - 1);
      default: addend = fold_i.operand;
    endcase
  end

  assign sum     = (TOD_W+1)'(total_q) + (TOD_W+1)'(addend);
  assign wrapped = (sum >= (TOD_W+1)'(DAY_SECONDS)) ?
                   TOD_W'(sum - (TOD_W+1)'(DAY_SECONDS)) : TOD_W'(sum);

  // Opcode decode.
  always_comb begin
    total_d = total_q;
    res_d.diff = '0;
    res_d.bad  = 1'b0;
    unique case (fold_i.op)
      OP_SET_CHECKED: begin
        if (fold_i.fields_ok) begin
          total_d = fold_i.operand;
        end else begin
          res_d.bad = 1'b1;
        end
      end
      OP_SET_NORM: total_d = fold_i.operand;
      OP_NEXT, OP_PREV, OP_SHIFT: total_d = wrapped;
      OP_DIFF: begin
        res_d.diff = $signed({1'b0, total_q}) - $signed({1'b0, fold_i.operand});
      end
      default: begin
      end
    endcase
    res_d.total = total_d;
  end

  // Stored time and output stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      v_q     <= 1'b0;
    end else begin
      if (take) total_q <= total_d;
      if (adv)  v_q     <= fold_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign core_valid_o = v_q;
  assign core_o       = res_q;

endmodule

@@ src/tdr_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_split
// Splits seconds of the day into hours, minutes and seconds by reciprocal
// multiplication over four stages; the last stage is the result register.
// ----------------------------------------------------------------------------
module tdr_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                core_valid_i,
  input  tdr_pkg::core_t      core_i,
  output logic                core_rdy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          hours_out_o,
  output logic [5:0]          minutes_out_o,
  output logic [5:0]          seconds_out_o,
  output logic signed [17:0]  difference_o,
  output logic                invalid_time_o
);
  import tdr_pkg::*;

  logic               s5_v_q, s6_v_q, s7_v_q, s8_v_q;
  logic               adv5, adv6, adv7, adv8;
  tod_t               s5_total_q;
  logic [4:0]         s5_hrs_q, s6_hrs_q, s7_hrs_q, s8_hrs_q;
  logic [11:0]        s6_rem_q, s7_rem_q;
  logic [5:0]         s7_min_q, s8_min_q, s8_sec_q;
  logic signed [DIFF_W-1:0] s5_diff_q, s6_diff_q, s7_diff_q, s8_diff_q;
  logic               s5_bad_q, s6_bad_q, s7_bad_q, s8_bad_q;
  logic [25:0]        hrs_prod;
  logic [26:0]        min_prod;
  logic [11:0]        rem_d;
  logic [5:0]         sec_d;

  assign adv8       = !s8_v_q || !out_stall_i;
  assign adv7       = !s7_v_q || adv8;
  assign adv6       = !s6_v_q || adv7;
  assign adv5       = !s5_v_q || adv6;
  assign core_rdy_o = adv5;

  // Hours from the upper bits of the time by reciprocal.
  assign hrs_prod = 26'(core_i.total[TOD_W-1:HOUR_LOW_BITS]) * 26'(HOUR_RECIP);
  // Seconds within the hour.
  assign rem_d    = 12'(s5_total_q - TOD_W'(32'(s5_hrs_q) * 32'(HOUR_SECONDS)));
  // Minutes within the hour by reciprocal.
  assign min_prod = 27'(s6_rem_q) * 27'(MIN_RECIP);
  // Seconds within the minute.
  assign sec_d    = 6'(s7_rem_q - 12'(s7_min_q) * 12'(MINUTE_SECONDS));

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
    end else begin
      if (adv5) s5_v_q <= core_valid_i;
      if (adv6) s6_v_q <= s5_v_q;
      if (adv7) s7_v_q <= s6_v_q;
      if (adv8) s8_v_q <= s7_v_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv5 && core_valid_i) begin
      s5_total_q <= core_i.total;
      s5_hrs_q   <= 5'(hrs_prod >> HOUR_RECIP_SHIFT);
      s5_diff_q  <= core_i.diff;
      s5_bad_q   <= core_i.bad;
    end
    if (adv6 && s5_v_q) begin
      s6_hrs_q  <= s5_hrs_q;
      s6_rem_q  <= rem_d;
      s6_diff_q <= s5_diff_q;
      s6_bad_q  <= s5_bad_q;
    end
    if (adv7 && s6_v_q) begin
      s7_hrs_q  <= s6_hrs_q;
      s7_rem_q  <= s6_rem_q;
      s7_min_q  <= 6'(min_prod >> MIN_RECIP_SHIFT);
      s7_diff_q <= s6_diff_q;
      s7_bad_q  <= s6_bad_q;
    end
    if (adv8 && s7_v_q) begin
      s8_hrs_q  <= s7_hrs_q;
      s8_min_q  <= s7_min_q;
      s8_sec_q  <= sec_d;
      s8_diff_q <= s7_diff_q;
      s8_bad_q  <= s7_bad_q;
    end
  end

  assign out_valid_o    = s8_v_q;
  assign hours_out_o    = s8_hrs_q;
  assign minutes_out_o  = s8_min_q;
  assign seconds_out_o  = s8_sec_q;
  assign difference_o   = s8_diff_q;
  assign invalid_time_o = s8_bad_q;

endmodule

@@ src/time_of_day_register.sv @@
`timescale 1ns / 1ps
// A result is shown for each accepted beat, one result per beat, in order.
// Throughput: one beat per cycle unless out_stall_i backs up the pipeline;
// the stored time is updated by one modular add in a single stage, so
// back-to-back operations need no spacing.
// Reset clears all stage valid bits and sets the time to 00:00:00.
// ----------------------------------------------------------------------------
// time_of_day_register
// 24-hour time-of-day register with checked and folded set, one-second steps,
// signed shift and a difference report, as a nine-stage pipeline.
// ----------------------------------------------------------------------------
module time_of_day_register (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic signed [15:0]  hours_in_i,
  input  logic signed [15:0]  minutes_in_i,
  input  logic signed [15:0]  seconds_in_i,
  input  logic signed [31:0]  shift_seconds_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          hours_out_o,
  output logic [5:0]          minutes_out_o,
  output logic [5:0]          seconds_out_o,
  output logic signed [17:0]  difference_o,
  output logic                invalid_time_o
);
  import tdr_pkg::*;

  logic  fold_valid, fold_rdy;
  fold_t fold;
  logic  core_valid, core_rdy;
  core_t core;

  // Input register and day folding of the operand.
  tdr_fold u_fold (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .hours_in_i      (hours_in_i),
    .minutes_in_i    (minutes_in_i),
    .seconds_in_i    (seconds_in_i),
    .shift_seconds_i (shift_seconds_i),
    .fold_valid_o    (fold_valid),
    .fold_o          (fold),
    .fold_rdy_i      (fold_rdy)
  );

  // Stored time and opcode execution.
  tdr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fold_valid_i (fold_valid),
    .fold_i       (fold),
    .fold_rdy_o   (fold_rdy),
    .core_valid_o (core_valid),
    .core_o       (core),
    .core_rdy_i   (core_rdy)
  );

  // Conversion to hours, minutes and seconds and result register.
  tdr_split u_split (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .core_valid_i   (core_valid),
    .core_i         (core),
    .core_rdy_o     (core_rdy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hours_out_o    (hours_out_o),
    .minutes_out_o  (minutes_out_o),
    .seconds_out_o  (seconds_out_o),
    .difference_o   (difference_o),
    .invalid_time_o (invalid_time_o)
  );

endmodule

@@ src/tdr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_checker
// Port-level checks for the time-of-day register, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdr_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_stall_o,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [4:0]          hours_out_o,
  input  logic [5:0]          minutes_out_o,
  input  logic [5:0]          seconds_out_o,
  input  logic signed [17:0]  difference_o,
  input  logic                invalid_time_o
);

  logic [35:0] out_beat;
  logic        out_held;
  logic        time_ok;
  logic        diff_ok;
  logic        bad_beat;
  logic        has_diff;

  // Result fields seen as one word, and the conditions the checks look at.
  assign out_beat = {hours_out_o, minutes_out_o, seconds_out_o, difference_o,
                     invalid_time_o};
  assign out_held = out_valid_o && out_stall_i;
  assign time_ok  = (hours_out_o <= 5'd23) && (minutes_out_o <= 6'd59)
                 && (seconds_out_o <= 6'd59);
  assign diff_ok  = (difference_o <= 18'sd86399) && (difference_o >= -18'sd86399);
  assign bad_beat = out_valid_o && invalid_time_o;
  assign has_diff = (difference_o != 18'sd0);

  // A stalled result beat stays put.
  `TDR_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_beat), "stalled beat changed")

  // The input stalls only while the pipeline is full behind a waiting result.
  `TDR_ASSERT(a_in_stall, in_stall_o |-> out_held, "input stalled with no waiting result")

  // The reported time is always a legal time of day.
  `TDR_ASSERT(a_time_legal, out_valid_o |-> time_ok, "result time out of range")

  // A difference always lies within one day either way.
  `TDR_ASSERT(a_diff_range, out_valid_o |-> diff_ok, "difference out of range")

  // A rejected set never carries a difference.
  `TDR_ASSERT_NEVER(a_bad_no_diff, bad_beat && has_diff, "difference on rejected set")

endmodule

bind time_of_day_register tdr_checker u_tdr_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time-of-day register. A queue of planned beats
// feeds a driver, and an in-bench clock model predicts every result. A monitor
// checks each output beat field by field against the oldest prediction. Both
// sides idle and stall at random, including one long output hold-off and two
// input pauses that let the pipeline drain.
// ----------------------------------------------------------------------------
module testbench;
  import tdr_pkg::*;

  // Opcodes six and seven are unused by the block and must act as no-ops.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_BEATS = 1850;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 700;

  // One planned input beat; a pause entry makes the driver wait for a drain.
  typedef struct {
    logic [2:0]         opcode;
    logic signed [15:0] hours_v;
    logic signed [15:0] minutes_v;
    logic signed [15:0] seconds_v;
    logic signed [31:0] shift_v;
    bit                 pause;
  } tod_beat_t;

  // One predicted output beat.
  typedef struct {
    logic [4:0]         hrs;
    logic [5:0]         mins;
    logic [5:0]         secs;
    logic signed [17:0] diff;
    logic               bad;
  } tod_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [2:0]         opcode_i        = '0;
  logic signed [15:0] hours_in_i      = '0;
  logic signed [15:0] minutes_in_i    = '0;
  logic signed [15:0] seconds_in_i    = '0;
  logic signed [31:0] shift_seconds_i = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b1;
  logic [4:0]         hours_out_o;
  logic [5:0]         minutes_out_o;
  logic [5:0]         seconds_out_o;
  logic signed [17:0] difference_o;
  logic               invalid_time_o;

  tod_beat_t   beat_plan[$];
  tod_result_t pending_times[$];
  tod_beat_t   offered;

  // Clock model of the block.
  int unsigned clk_hours;
  int unsigned clk_minutes;
  int unsigned clk_seconds;

  int  errors      = 0;
  int  beats_in    = 0;
  bit  in_taken    = 1'b0;
  bit  draining    = 1'b0;
  int  send_gap    = 0;
  int  send_calm   = 0;
  int  stall_left  = 0;
  int  recv_calm   = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;

  time_of_day_register dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .hours_in_i      (hours_in_i),
    .minutes_in_i    (minutes_in_i),
    .seconds_in_i    (seconds_in_i),
    .shift_seconds_i (shift_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hours_out_o     (hours_out_o),
    .minutes_out_o   (minutes_out_o),
    .seconds_out_o   (seconds_out_o),
    .difference_o    (difference_o),
    .invalid_time_o  (invalid_time_o)
  );

  // Place a signed second count into one day with floor modulo.
  function automatic longint day_fold(longint t);
    longint r;
    r = t % DAY_SECONDS;
    if (r < 0) r += DAY_SECONDS;
    return r;
  endfunction

  function automatic longint clock_total();
    return longint'(clk_hours) * HOUR_SECONDS + longint'(clk_minutes) * MINUTE_SECONDS
         + longint'(clk_seconds);
  endfunction

  function automatic void load_clock(longint t);
    longint d;
    d = day_fold(t);
    clk_hours   = int'(d / HOUR_SECONDS);
    clk_minutes = int'((d / MINUTE_SECONDS) % MINUTE_SECONDS);
    clk_seconds = int'(d % MINUTE_SECONDS);
  endfunction

  // Apply one beat to the clock model and return the time it reports.
  function automatic tod_result_t advance_clock(tod_beat_t b);
    longint      given;
    tod_result_t r;
    given = longint'(b.hours_v) * HOUR_SECONDS + longint'(b.minutes_v) * MINUTE_SECONDS
          + longint'(b.seconds_v);
    r.diff = '0;
    r.bad  = 1'b0;
    case (b.opcode)
      OP_SET_CHECKED: begin
        if (b.hours_v >= 0 && b.hours_v <= MAX_HOURS && b.minutes_v >= 0 &&
            b.minutes_v <= MAX_MINUTES && b.seconds_v >= 0 && b.seconds_v <= MAX_SECONDS) begin
          clk_hours   = int'(b.hours_v);
          clk_minutes = int'(b.minutes_v);
          clk_seconds = int'(b.seconds_v);
        end else begin
          r.bad = 1'b1;
        end
      end
      OP_SET_NORM: load_clock(given);
      OP_NEXT:     load_clock(clock_total() + 1);
      OP_PREV:     load_clock(clock_total() - 1);
      OP_SHIFT:    load_clock(clock_total() + longint'(b.shift_v));
      OP_DIFF:     r.diff = 18'(clock_total() - day_fold(given));
      default: begin
      end
    endcase
    r.hrs  = 5'(clk_hours);
    r.mins = 6'(clk_minutes);
    r.secs = 6'(clk_seconds);
    return r;
  endfunction

  // Idle length: mostly none or short, a few long, with idle-free stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 950) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // A time field: mostly in range, sometimes just outside, sometimes anything.
  function automatic logic signed [15:0] pick_field(int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom_range(0, hi));
    if (r < 7) return 16'(int'($urandom_range(0, 2 * hi + 40)) - (hi + 20));
    return 16'($urandom());
  endfunction

  function automatic logic signed [31:0] pick_shift();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return 32'(int'($urandom_range(0, 200)) - 100);
    if (r == 1) return 32'(int'($urandom_range(0, 400000)) - 200000);
    return 32'($urandom());
  endfunction

  task automatic add_beat(logic [2:0] op, int h, int m, int s, int sh);
    tod_beat_t b;
    b.opcode    = op;
    b.hours_v   = 16'(h);
    b.minutes_v = 16'(m);
    b.seconds_v = 16'(s);
    b.shift_v   = 32'(sh);
    b.pause     = 1'b0;
    beat_plan.push_back(b);
  endtask

  task automatic add_pause();
    tod_beat_t b;
    b = '{opcode: OP_SPARE_A, hours_v: '0, minutes_v: '0, seconds_v: '0,
          shift_v: '0, pause: 1'b1};
    beat_plan.push_back(b);
  endtask

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Input side: record accepted beats and predict their results.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_times.push_back(advance_clock(offered));
      beats_in <= beats_in + 1;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: offer the next planned beat at the falling edge.
  always @(negedge clk_i) begin
    tod_beat_t nxt;
    bit        nv;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      nv = 1'b0;
      if (draining) begin
        if (pending_times.size() == 0) draining = 1'b0;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (beat_plan.size() > 0) begin
        nxt = beat_plan.pop_front();
        if (nxt.pause) begin
          draining = 1'b1;
        end else begin
          offered         = nxt;
          opcode_i        <= nxt.opcode;
          hours_in_i      <= nxt.hours_v;
          minutes_in_i    <= nxt.minutes_v;
          seconds_in_i    <= nxt.seconds_v;
          shift_seconds_i <= nxt.shift_v;
          nv              = 1'b1;
          send_gap        = pick_gap(send_calm);
        end
      end
      in_valid_i <= nv;
    end
  end

  // Receiver stall, with one long hold-off once traffic is under way.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && beats_in >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap(recv_calm);
      end
    end
  end

  // Monitor: compare each output beat with the oldest prediction.
  always @(posedge clk_i) begin
    tod_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_times.size() == 0) begin
        $error("unexpected output beat %0d:%0d:%0d", hours_out_o, minutes_out_o,
               seconds_out_o);
        errors++;
      end else begin
        want = pending_times.pop_front();
        if (hours_out_o !== want.hrs) begin
          $error("hours_out: expected %0d, actual %0d", want.hrs, hours_out_o);
          errors++;
        end
        if (minutes_out_o !== want.mins) begin
          $error("minutes_out: expected %0d, actual %0d", want.mins, minutes_out_o);
          errors++;
        end
        if (seconds_out_o !== want.secs) begin
          $error("seconds_out: expected %0d, actual %0d", want.secs, seconds_out_o);
          errors++;
        end
        if (difference_o !== want.diff) begin
          $error("difference: expected %0d, actual %0d", want.diff, difference_o);
          errors++;
        end
        if (invalid_time_o !== want.bad) begin
          $error("invalid_time: expected %0d, actual %0d", want.bad, invalid_time_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk_i);
    $display("time_of_day_register regression: fail");
    $finish;
  end

  // Stimulus plan, reset and end of run.
  initial begin
    int r;
    clk_hours   = 0;
    clk_minutes = 0;
    clk_seconds = 0;

    // Directed: range edges of set, wrap of one-second steps, folding at exact
    // negative days, extreme shifts, extreme differences and spare opcodes.
    add_beat(OP_SET_CHECKED, 23, 59, 59, 0);
    add_beat(OP_NEXT, 7, 7, 7, -1);
    add_beat(OP_PREV, 0, 0, 0, 0);
    add_beat(OP_SET_CHECKED, 0, 0, 0, 0);
    add_beat(OP_PREV, -1, -1, -1, 1);
    add_beat(OP_SET_CHECKED, 24, 0, 0, 0);
    add_beat(OP_SET_CHECKED, 12, 60, 0, 0);
    add_beat(OP_SET_CHECKED, 12, 0, 60, 0);
    add_beat(OP_SET_CHECKED, -1, 0, 0, 0);
    add_beat(OP_SET_CHECKED, -32768, -32768, -32768, 0);
    add_beat(OP_SET_CHECKED, 32767, 32767, 32767, 0);
    add_beat(OP_SET_NORM, -24, 0, 0, 0);
    add_beat(OP_SET_NORM, -48, 0, 0, 0);
    add_beat(OP_SET_NORM, 32767, 32767, 32767, 0);
    add_beat(OP_SET_NORM, -32768, -32768, -32768, 0);
    add_beat(OP_SHIFT, 1, 2, 3, 32'h7fff_ffff);
    add_beat(OP_SHIFT, 0, 0, 0, 32'h8000_0000);
    add_beat(OP_SHIFT, 0, 0, 0, -DAY_SECONDS);
    add_beat(OP_SET_CHECKED, 0, 0, 0, 0);
    add_beat(OP_DIFF, 23, 59, 59, 0);
    add_beat(OP_SET_CHECKED, 23, 59, 59, 0);
    add_beat(OP_DIFF, 0, 0, 0, 0);
    add_beat(OP_DIFF, -24, 0, 0, 0);
    add_beat(OP_SPARE_A, 5, 5, 5, 5);
    add_beat(OP_SPARE_B, -5, -5, -5, -5);
    add_pause();

    // Random traffic, with one drain pause in the middle.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      tod_beat_t b;
      r = $urandom_range(0, 99);
      if (r < 25)      b.opcode = OP_SET_CHECKED;
      else if (r < 40) b.opcode = OP_SET_NORM;
      else if (r < 55) b.opcode = OP_NEXT;
      else if (r < 70) b.opcode = OP_PREV;
      else if (r < 82) b.opcode = OP_SHIFT;
      else if (r < 94) b.opcode = OP_DIFF;
      else if (r < 97) b.opcode = OP_SPARE_A;
      else             b.opcode = OP_SPARE_B;
      b.hours_v   = pick_field(MAX_HOURS);
      b.minutes_v = pick_field(MAX_MINUTES);
      b.seconds_v = pick_field(MAX_SECONDS);
      b.shift_v   = pick_shift();
      b.pause     = 1'b0;
      beat_plan.push_back(b);
      if (i == RANDOM_BEATS / 2) add_pause();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beat_plan.size() != 0 || in_valid_i || draining) @(posedge clk_i);
    while (pending_times.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("time_of_day_register regression: pass");
    end else begin
      $display("time_of_day_register regression: fail");
    end
    $finish;
  end

endmodule
